@@ src/bar_pkg.sv @@
// Shared types and constants for the bridge converter serial reader and averager.
// Used by bar_serial, the top level and the testbench; depends on nothing.
package bar_pkg;

   localparam int DATA_BITS_DEFAULT = 24;
   localparam int READING_W         = 24;
   localparam int RESULT_W          = 25;
   localparam int SUM_W             = 32;
   localparam int COUNT_W           = 8;
   localparam int GAIN_W            = 2;
   localparam int CSR_ADDR_W        = 4;
   localparam int CSR_DATA_W        = 32;

   localparam logic [1:0] CSR_GAIN_PULSES = 2'd0;
   localparam logic [1:0] CSR_AVG_COUNT   = 2'd1;
   localparam logic [1:0] CSR_ZERO_OFFSET = 2'd2;

   localparam logic [GAIN_W-1:0]  GAIN_RESET = 2'd1;
   localparam logic [COUNT_W-1:0] AVG_RESET  = 8'd1;

   localparam logic signed [SUM_W-1:0] READ_MAX = 32'sd8388607;
   localparam logic signed [SUM_W-1:0] READ_MIN = -32'sd8388608;

   typedef struct packed {
      logic                        clock_level;
      logic                        reading_valid;
      logic signed [READING_W-1:0] reading_value;
      logic                        result_due;
      logic signed [SUM_W-1:0]     sum;
      logic [COUNT_W-1:0]          count;
   } tick_type;

endpackage

@@ src/bar_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the top level for the average of the summed readings.
module bar_divider #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             run_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] rem_in;
   logic [NUM_W-1:0] work_ff;
   logic [NUM_W-1:0] work_in;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, work_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      diff    = trial - {1'b0, den_ff};
      rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      work_in = {work_ff[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            work_ff <= numer;
            den_ff  <= denom;
         end else if (run_ff) begin
            rem_ff  <= rem_in;
            work_ff <= work_in;
            cnt_ff  <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = work_ff;

endmodule

@@ src/bar_serial.sv @@
// Serial clock sequencer, bit shifter and reading accumulator, one tick per step.
// Depends on bar_pkg for the tick record and reading limits.
module bar_serial #(
   parameter int DATA_BITS = bar_pkg::DATA_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic                             data_level,
   input  logic [bar_pkg::GAIN_W-1:0]       gain_pulses,
   input  logic [bar_pkg::COUNT_W-1:0]      avg_count,
   output bar_pkg::tick_type                tick
);

   localparam int BIT_W = $clog2(DATA_BITS);

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_BIT_HI,
      PH_BIT_LO,
      PH_PULSE_HI,
      PH_PULSE_LO
   } phase_type;

   phase_type                              phase_ff, phase_in;
   logic [BIT_W-1:0]                       bit_ff, bit_in;
   logic [DATA_BITS-1:0]                   shift_ff, shift_in;
   logic [bar_pkg::GAIN_W-1:0]             pulse_ff, pulse_in;
   logic signed [bar_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic [bar_pkg::COUNT_W-1:0]            count_ff, count_in;

   logic [bar_pkg::GAIN_W-1:0]             pulse_next;
   logic signed [bar_pkg::SUM_W-1:0]       raw;
   logic signed [bar_pkg::SUM_W-1:0]       sat;
   logic signed [bar_pkg::SUM_W-1:0]       sum_add;
   logic [bar_pkg::COUNT_W-1:0]            count_add;
   logic [bar_pkg::COUNT_W-1:0]            need;
   logic                                   due;

   always_comb begin
      pulse_next = pulse_ff + bar_pkg::GAIN_W'(1);
      raw        = bar_pkg::SUM_W'($signed(shift_ff));
      if (raw > bar_pkg::READ_MAX) begin
         sat = bar_pkg::READ_MAX;
      end else if (raw < bar_pkg::READ_MIN) begin
         sat = bar_pkg::READ_MIN;
      end else begin
         sat = raw;
      end
      sum_add   = sum_ff + sat;
      count_add = count_ff + bar_pkg::COUNT_W'(1);
      need      = (avg_count == '0) ? bar_pkg::COUNT_W'(1) : avg_count;
      due       = count_add >= need;

      phase_in = phase_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      pulse_in = pulse_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      tick     = '0;

      unique case (phase_ff)
         PH_BIT_HI: begin
            tick.clock_level = 1'b1;
            phase_in         = PH_BIT_LO;
         end
         PH_BIT_LO: begin
            shift_in = {shift_ff[DATA_BITS-2:0], data_level};
            if (bit_ff == BIT_W'(DATA_BITS - 1)) begin
               bit_in   = '0;
               pulse_in = '0;
               phase_in = PH_PULSE_HI;
            end else begin
               bit_in   = bit_ff + BIT_W'(1);
               phase_in = PH_BIT_HI;
            end
         end
         PH_PULSE_HI: begin
            tick.clock_level = 1'b1;
            phase_in         = PH_PULSE_LO;
         end
         PH_PULSE_LO: begin
            if (pulse_next >= gain_pulses || pulse_next == '0) begin
               tick.reading_valid = 1'b1;
               tick.reading_value = sat[bar_pkg::READING_W-1:0];
               tick.result_due    = due;
               tick.sum           = sum_add;
               tick.count         = count_add;
               sum_in             = due ? '0 : sum_add;
               count_in           = due ? '0 : count_add;
               pulse_in           = '0;
               shift_in           = '0;
               phase_in           = PH_WAIT;
            end else begin
               pulse_in = pulse_next;
               phase_in = PH_PULSE_HI;
            end
         end
         default: begin
            // wait for data low; unused codes fall back here
            phase_in = PH_WAIT;
            if (!data_level) begin
               bit_in   = '0;
               shift_in = '0;
               phase_in = PH_BIT_HI;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         bit_ff   <= '0;
         shift_ff <= '0;
         pulse_ff <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         pulse_ff <= pulse_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ src/bridge_adc_serial_reader_averager.sv @@
// Top level of the bridge converter serial reader and averager.
// Depends on bar_pkg, bar_serial and bar_divider.
// Usage:
//   Each req_ transfer is one half-clock tick carrying the sampled data pin
//   level; each tick yields exactly one rsp_ transfer with the serial clock
//   level to drive, the raw reading when a conversion completes, and the
//   averaged, offset-corrected result every avg_count readings. The user
//   writes registers gain_pulses (0x0), avg_count (0x4), zero_offset (0x8)
//   via the csr_ port while the block is idle; it is not enforced.
// Throughput:
//   A tick without a result is answered in the cycle after its transfer, so a
//   tick can be taken every cycle while the response side keeps up.
//   A tick that closes an average runs the serial divider, one quotient bit
//   per cycle over 32 bits; req_stall stays high until the divider is done
//   and its result is registered into the response.
// Reset: synchronous, active high. The registers return to 1, 1 and 0, the
//   sequencer waits for data low and the running sum is cleared.
// Receiver stall: the response register holds its item while rsp_stall is
//   high; no new tick is taken until it is transferred.
module bridge_adc_serial_reader_averager #(
   parameter int DATA_BITS = bar_pkg::DATA_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_data_level,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_clock_level,
   output logic                                   rsp_reading_valid,
   output logic signed [bar_pkg::READING_W-1:0]   rsp_reading_value,
   output logic                                   rsp_result_valid,
   output logic signed [bar_pkg::RESULT_W-1:0]    rsp_result_value,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [bar_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [bar_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [bar_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   typedef enum logic {
      ST_IDLE,
      ST_DIVIDE
   } state_type;

   state_type                                 state_ff;
   logic                                      rsp_valid_ff;
   logic                                      clock_level_ff;
   logic                                      reading_valid_ff;
   logic signed [bar_pkg::READING_W-1:0]      reading_value_ff;
   logic                                      result_valid_ff;
   logic signed [bar_pkg::RESULT_W-1:0]       result_value_ff;
   logic                                      neg_ff;

   logic [bar_pkg::GAIN_W-1:0]                gain_ff;
   logic [bar_pkg::COUNT_W-1:0]               avg_ff;
   logic signed [bar_pkg::READING_W-1:0]      offset_ff;

   bar_pkg::tick_type                         tick;
   logic                                      accept;
   logic                                      csr_write;
   logic                                      div_start;
   logic                                      div_done;
   logic [bar_pkg::SUM_W-1:0]                 div_quot;
   logic [bar_pkg::SUM_W-1:0]                 sum_mag;
   logic signed [bar_pkg::RESULT_W-1:0]       avg;
   logic signed [bar_pkg::RESULT_W-1:0]       result_calc;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= bar_pkg::GAIN_RESET;
         avg_ff    <= bar_pkg::AVG_RESET;
         offset_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            bar_pkg::CSR_GAIN_PULSES: gain_ff   <= csr_pwdata[bar_pkg::GAIN_W-1:0];
            bar_pkg::CSR_AVG_COUNT:   avg_ff    <= csr_pwdata[bar_pkg::COUNT_W-1:0];
            bar_pkg::CSR_ZERO_OFFSET: offset_ff <= csr_pwdata[bar_pkg::READING_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         bar_pkg::CSR_GAIN_PULSES: csr_prdata = bar_pkg::CSR_DATA_W'(gain_ff);
         bar_pkg::CSR_AVG_COUNT:   csr_prdata = bar_pkg::CSR_DATA_W'(avg_ff);
         bar_pkg::CSR_ZERO_OFFSET: csr_prdata = bar_pkg::CSR_DATA_W'(unsigned'(offset_ff));
         default:                  csr_prdata = '0;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign div_start = accept && tick.result_due;

   bar_serial #(
      .DATA_BITS (DATA_BITS)
   ) u_serial (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .data_level  (req_data_level),
      .gain_pulses (gain_ff),
      .avg_count   (avg_ff),
      .tick        (tick)
   );

   assign sum_mag = tick.sum[bar_pkg::SUM_W-1] ? (~tick.sum + bar_pkg::SUM_W'(1)) : tick.sum;

   bar_divider #(
      .NUM_W (bar_pkg::SUM_W),
      .DEN_W (bar_pkg::COUNT_W)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (sum_mag),
      .denom (tick.count),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      avg = neg_ff ? -$signed(div_quot[bar_pkg::RESULT_W-1:0])
                   : $signed(div_quot[bar_pkg::RESULT_W-1:0]);
      result_calc = avg - bar_pkg::RESULT_W'(offset_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  clock_level_ff   <= tick.clock_level;
                  reading_valid_ff <= tick.reading_valid;
                  reading_value_ff <= tick.reading_value;
                  result_valid_ff  <= tick.result_due;
                  result_value_ff  <= '0;
                  neg_ff           <= tick.sum[bar_pkg::SUM_W-1];
                  if (tick.result_due) begin
                     state_ff <= ST_DIVIDE;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  result_value_ff <= result_calc;
                  rsp_valid_ff    <= 1'b1;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_clock_level   = clock_level_ff;
   assign rsp_reading_valid = reading_valid_ff;
   assign rsp_reading_value = reading_value_ff;
   assign rsp_result_valid  = result_valid_ff;
   assign rsp_result_value  = result_value_ff;

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside divide state");

   a_done_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      div_done |=> rsp_valid)
      else $error("divider result not presented");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !accept)
      else $error("tick taken while response held");

   a_result_with_reading: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_valid) |-> rsp_reading_valid)
      else $error("result without reading");

endmodule

@@ test/tb_bridge_adc_serial_reader_averager.sv @@
`timescale 1ns / 1ps
// Testbench for bridge_adc_serial_reader_averager: drives data pin ticks and APB register writes,
// predicts every response transfer with its own sequencer and averager model. Needs bar_pkg.
module tb_bridge_adc_serial_reader_averager;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TICK_TARGET    = 1300;

   typedef enum logic [2:0] {
      WAIT_LOW, BIT_HIGH, BIT_LOW, PULSE_HIGH, PULSE_LOW
   } seq_phase_type;

   typedef struct packed {
      logic                                 clk;
      logic                                 rd_v;
      logic signed [bar_pkg::READING_W-1:0] rd_val;
      logic                                 res_v;
      logic signed [bar_pkg::RESULT_W-1:0]  res_val;
   } tick_answer_type;

   class averager_scoreboard;
      logic [bar_pkg::GAIN_W-1:0]    gain;
      logic [bar_pkg::COUNT_W-1:0]   avg_n;
      logic [bar_pkg::READING_W-1:0] tare;
      seq_phase_type                 ph;
      int                            bits_in;
      logic [31:0]                   word;
      logic [1:0]                    pulses;
      longint                        sum;
      int                            summed;
      tick_answer_type               due_answers[$];
      int                            errors;
      int                            readings;
      int                            averages;

      function new();
         gain     = bar_pkg::GAIN_RESET;
         avg_n    = bar_pkg::AVG_RESET;
         tare     = '0;
         ph       = WAIT_LOW;
         bits_in  = 0;
         word     = '0;
         pulses   = '0;
         sum      = 0;
         summed   = 0;
         errors   = 0;
         readings = 0;
         averages = 0;
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      function void set_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            bar_pkg::CSR_GAIN_PULSES: gain  = value[bar_pkg::GAIN_W-1:0];
            bar_pkg::CSR_AVG_COUNT:   avg_n = value[bar_pkg::COUNT_W-1:0];
            bar_pkg::CSR_ZERO_OFFSET: tare  = value[bar_pkg::READING_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_tick(logic d);
         tick_answer_type a;
         longint          rd;
         longint          avg;
         int              need;
         a = '0;
         case (ph)
            BIT_HIGH: begin
               a.clk = 1'b1;
               ph = BIT_LOW;
            end
            BIT_LOW: begin
               word = {word[30:0], d};
               bits_in++;
               if (bits_in >= bar_pkg::DATA_BITS_DEFAULT) begin
                  bits_in = 0;
                  pulses  = '0;
                  ph      = PULSE_HIGH;
               end else begin
                  ph = BIT_HIGH;
               end
            end
            PULSE_HIGH: begin
               a.clk = 1'b1;
               ph = PULSE_LOW;
            end
            PULSE_LOW: begin
               pulses = pulses + 2'd1;
               if (pulses >= gain || pulses == 2'd0) begin
                  need   = (avg_n == 0) ? 1 : int'(avg_n);
                  rd     = longint'($signed(word[bar_pkg::READING_W-1:0]));
                  a.rd_v = 1'b1;
                  a.rd_val = rd[bar_pkg::READING_W-1:0];
                  sum += rd;
                  summed++;
                  if (summed >= need) begin
                     avg       = sum / summed;
                     avg       = avg - longint'($signed(tare));
                     a.res_v   = 1'b1;
                     a.res_val = avg[bar_pkg::RESULT_W-1:0];
                     sum       = 0;
                     summed    = 0;
                  end
                  pulses = '0;
                  word   = '0;
                  ph     = WAIT_LOW;
               end else begin
                  ph = PULSE_HIGH;
               end
            end
            default: begin
               ph = WAIT_LOW;
               if (d == 1'b0) begin
                  bits_in = 0;
                  word    = '0;
                  ph      = BIT_HIGH;
               end
            end
         endcase
         due_answers.push_back(a);
      endfunction

      task check_tick(tick_answer_type got);
         tick_answer_type want;
         if (due_answers.size() == 0) begin
            report("response transfer with no tick outstanding");
            return;
         end
         want = due_answers.pop_front();
         if (got.clk !== want.clk)
            report($sformatf("clock_level got %b want %b", got.clk, want.clk));
         if (got.rd_v !== want.rd_v)
            report($sformatf("reading_valid got %b want %b", got.rd_v, want.rd_v));
         if (got.rd_val !== want.rd_val)
            report($sformatf("reading_value got %0d want %0d", got.rd_val, want.rd_val));
         if (got.res_v !== want.res_v)
            report($sformatf("result_valid got %b want %b", got.res_v, want.res_v));
         if (got.res_val !== want.res_val)
            report($sformatf("result_value got %0d want %0d", got.res_val, want.res_val));
         if (want.rd_v)
            readings++;
         if (want.res_v)
            averages++;
      endtask
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic                                 req_data_level;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic                                 rsp_clock_level;
   logic                                 rsp_reading_valid;
   logic signed [bar_pkg::READING_W-1:0] rsp_reading_value;
   logic                                 rsp_result_valid;
   logic signed [bar_pkg::RESULT_W-1:0]  rsp_result_value;
   logic                                 csr_psel;
   logic                                 csr_penable;
   logic                                 csr_pwrite;
   logic [bar_pkg::CSR_ADDR_W-1:0]       csr_paddr;
   logic [bar_pkg::CSR_DATA_W-1:0]       csr_pwdata;
   logic [bar_pkg::CSR_DATA_W-1:0]       csr_prdata;
   logic                                 csr_pready;

   averager_scoreboard sb;
   int  ticks_sent;
   int  settings;
   int  gap_pct;
   int  stall_pct;
   bit  quiet;
   int  idle_cycles;

   bridge_adc_serial_reader_averager DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_level    (req_data_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_clock_level   (rsp_clock_level),
      .rsp_reading_valid (rsp_reading_valid),
      .rsp_reading_value (rsp_reading_value),
      .rsp_result_valid  (rsp_result_valid),
      .rsp_result_value  (rsp_result_value),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      tick_answer_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.clk     = rsp_clock_level;
         got.rd_v    = rsp_reading_valid;
         got.rd_val  = rsp_reading_value;
         got.res_v   = rsp_result_valid;
         got.res_val = rsp_result_value;
         sb.check_tick(got);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TIMEOUT: no transfer for %0d cycles", idle_cycles);
         $display("tb_bridge_adc_serial_reader_averager: done, errors");
         $finish;
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet || $urandom_range(1, 100) > stall_pct) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17) - 1) @(negedge clock);
         end
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_all(input int g, input int n, input int off);
      csr_write(bar_pkg::CSR_GAIN_PULSES, 32'(g));
      csr_write(bar_pkg::CSR_AVG_COUNT, 32'(n));
      csr_write(bar_pkg::CSR_ZERO_OFFSET, 32'(off));
      settings++;
   endtask

   task automatic send_tick(input logic d);
      @(negedge clock);
      if (!quiet && $urandom_range(1, 100) <= gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_level <= d;
      do @(posedge clock); while (req_stall);
      sb.note_tick(d);
      ticks_sent++;
   endtask

   task automatic send_conversion(input logic [bar_pkg::READING_W-1:0] value);
      int g;
      repeat ($urandom_range(0, 3)) send_tick(1'b1);
      send_tick(1'b0);
      for (int i = bar_pkg::READING_W - 1; i >= 0; i--) begin
         send_tick(1'($urandom));
         send_tick(value[i]);
      end
      g = (sb.gain == 0) ? 1 : int'(sb.gain);
      repeat (2 * g) send_tick(1'($urandom));
   endtask

   task automatic send_noise(input int n);
      repeat (n) send_tick(1'($urandom));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.due_answers.size() != 0) @(posedge clock);
   endtask

   function automatic logic [bar_pkg::READING_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'h000000;
         3: return 24'hFFFFFF;
         default: return bar_pkg::READING_W'($urandom);
      endcase
   endfunction

   initial begin
      int g;
      int n;
      int off;
      sb             = new();
      ticks_sent     = 0;
      settings       = 0;
      gap_pct        = 0;
      stall_pct      = 0;
      quiet          = 1'b0;
      idle_cycles    = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_level = 1'b1;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_tick(1'b1);
      send_tick(1'b1);
      send_conversion(24'h7FFFFF);
      send_conversion(24'h800000);
      drain();
      set_all(0, 0, 8388607);
      send_conversion(24'h800000);
      drain();
      gap_pct   = 10;
      stall_pct = 10;
      set_all(3, 2, -8388608);
      send_conversion(24'h7FFFFF);
      send_conversion(24'h7FFFFF);
      drain();
      set_all(2, 255, 12345);
      send_conversion(24'hFFFFFF);
      send_conversion(24'hFFFFFE);
      send_conversion(24'h000001);
      drain();
      csr_write(bar_pkg::CSR_AVG_COUNT, 32'd2);
      send_conversion(24'hFFFFFF);
      drain();

      while (ticks_sent < TICK_TARGET) begin
         quiet = (ticks_sent > TICK_TARGET - 250);
         case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 10;
            default: gap_pct = 30;
         endcase
         case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 10;
            default: stall_pct = 30;
         endcase
         g = $urandom_range(0, 3);
         case ($urandom_range(0, 9))
            0: n = 0;
            1: n = 255;
            2: n = 1;
            default: n = $urandom_range(2, 6);
         endcase
         case ($urandom_range(0, 5))
            0: off = -8388608;
            1: off = 8388607;
            2: off = 0;
            default: off = int'($signed(bar_pkg::READING_W'($urandom)));
         endcase
         set_all(g, n, off);
         repeat ($urandom_range(2, 6)) begin
            if (ticks_sent < TICK_TARGET) begin
               if ($urandom_range(0, 5) == 0)
                  send_noise($urandom_range(1, 20));
               else
                  send_conversion(pick_word());
            end
         end
         if (ticks_sent < TICK_TARGET && $urandom_range(0, 2) == 0)
            send_noise($urandom_range(1, 40));
         drain();
      end

      repeat (40) @(posedge clock);
      if (sb.due_answers.size() != 0)
         sb.report($sformatf("%0d ticks never answered", sb.due_answers.size()));
      $display("Covered %0d ticks, %0d conversions and %0d averaged results",
               ticks_sent, sb.readings, sb.averages);
      $display("over %0d register settings with gaps and stalls on both channels", settings);
      if (sb.errors == 0) begin
         $display("tb_bridge_adc_serial_reader_averager: done, clean");
      end else begin
         $display("tb_bridge_adc_serial_reader_averager: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/bar_pkg.sv
src/bar_divider.sv
src/bar_serial.sv
src/bridge_adc_serial_reader_averager.sv
test/tb_bridge_adc_serial_reader_averager.sv
